/* src/wgh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wgh_pkg;

  // Grid geometry
  localparam int GridSize  = 128;
  localparam int CoordW    = 7;
  localparam int AddrW     = 2 * CoordW;
  localparam int CellCount = GridSize * GridSize;
  localparam int FrameCount = 3;
  localparam int HeightW   = 16;
  localparam int GainW     = 16;
  localparam int QShift    = 14;

  // Sliding window over the current frame: two rows and one cell
  localparam int WinLen = 2 * GridSize + 1;
  localparam int TapS   = 0;
  localparam int TapE   = GridSize - 1;
  localparam int TapC   = GridSize;
  localparam int TapW   = GridSize + 1;
  localparam int TapN   = 2 * GridSize;

  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(CellCount - 1);
  localparam logic [CoordW-1:0] LastCoord = CoordW'(GridSize - 1);

  localparam logic signed [HeightW-1:0] HeightMax = 16'sh7fff;
  localparam logic signed [HeightW-1:0] HeightMin = -16'sh8000;

  // Configuration registers
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgCoupling = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCenter   = 1'b1;
  localparam logic [GainW-1:0] CouplingReset = 16'd419;
  localparam logic [GainW-1:0] CenterReset   = 16'd31091;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdAdd   = 2'd1,
    CmdStep  = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic [CoordW-1:0]          cell_x;
    logic [CoordW-1:0]          cell_y;
    logic signed [HeightW-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic signed [HeightW-1:0]  height;
    logic                       saturated;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                       clr_we;
    logic                       step_issue;
    logic                       add_we;
    logic                       rotate;
    logic                       zero_index;
    logic                       sat_clr;
    logic [AddrW-1:0]           cnt;
    logic [AddrW-1:0]           cell_addr;
    logic signed [HeightW-1:0]  amount;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic signed [HeightW-1:0]  cur_height;
    logic                       add_sat;
    logic                       pipe_empty;
    logic                       step_sat;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/wgh_frame_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// One height frame: one write port, one read port with registered data.
module wgh_frame_ram (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [wgh_pkg::AddrW-1:0]          waddr_i,
  input  wire logic signed [wgh_pkg::HeightW-1:0] wdata_i,
  input  wire logic [wgh_pkg::AddrW-1:0]          raddr_i,
  output logic signed [wgh_pkg::HeightW-1:0]      rdata_o
);

  logic signed [wgh_pkg::HeightW-1:0] mem_q [wgh_pkg::CellCount];
  logic signed [wgh_pkg::HeightW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/wgh_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module wgh_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire wgh_pkg::dp_cmd_t                cmd_i,
  input  wire logic [wgh_pkg::GainW-1:0]       coupling_i,
  input  wire logic [wgh_pkg::GainW-1:0]       center_i,
  output wgh_pkg::dp_stat_t                    stat_o
);

  localparam int HW = wgh_pkg::HeightW;
  localparam int AW = wgh_pkg::AddrW;
  localparam int CW = wgh_pkg::CoordW;
  localparam int NsumW = HW + 2;
  localparam int PaW = wgh_pkg::GainW + 1 + NsumW;
  localparam int PbW = wgh_pkg::GainW + 1 + HW;
  localparam int AccW = PaW + 2;
  localparam int RndW = AccW - wgh_pkg::QShift;

  // Frame ring index and the roles derived from it
  logic [1:0] fi_q, nxt_idx, prv_idx;

  always_comb begin
    unique case (fi_q)
      2'd0: begin
        nxt_idx = 2'd1;
        prv_idx = 2'd2;
      end
      2'd1: begin
        nxt_idx = 2'd2;
        prv_idx = 2'd0;
      end
      default: begin
        nxt_idx = 2'd0;
        prv_idx = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q <= 2'd0;
    end else if (cmd_i.zero_index) begin
      fi_q <= 2'd0;
    end else if (cmd_i.rotate) begin
      fi_q <= nxt_idx;
    end
  end

  // Step write-back stage registers (declared early for the write port mux)
  logic                 wr_v_q;
  logic [AW-1:0]        wr_a_q;
  logic signed [HW-1:0] wr_d_q;

  // Memory ports
  logic [AW-1:0]        cur_raddr, prv_raddr, waddr;
  logic signed [HW-1:0] wdata, add_val;
  logic signed [HW-1:0] rdata [wgh_pkg::FrameCount];
  logic signed [HW-1:0] rd_cur, rd_prv;

  assign cur_raddr = cmd_i.step_issue ? cmd_i.cnt : cmd_i.cell_addr;
  assign prv_raddr = cmd_i.cnt - AW'(wgh_pkg::GridSize);

  always_comb begin
    if (cmd_i.clr_we) begin
      waddr = cmd_i.cnt;
      wdata = '0;
    end else if (cmd_i.add_we) begin
      waddr = cmd_i.cell_addr;
      wdata = add_val;
    end else begin
      waddr = wr_a_q;
      wdata = wr_d_q;
    end
  end

  for (genvar k = 0; k < wgh_pkg::FrameCount; k++) begin : g_frame
    localparam logic [1:0] K = 2'(k);
    logic          we;
    logic [AW-1:0] raddr;

    assign we    = cmd_i.clr_we || (cmd_i.add_we && fi_q == K) ||
                   (wr_v_q && nxt_idx == K);
    assign raddr = (prv_idx == K) ? prv_raddr : cur_raddr;

    wgh_frame_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (raddr),
      .rdata_o (rdata[k])
    );
  end

  always_comb begin
    unique case (fi_q)
      2'd0:    rd_cur = rdata[0];
      2'd1:    rd_cur = rdata[1];
      default: rd_cur = rdata[2];
    endcase
    unique case (prv_idx)
      2'd0:    rd_prv = rdata[0];
      2'd1:    rd_prv = rdata[1];
      default: rd_prv = rdata[2];
    endcase
  end

  // Saturating add for the add command
  logic signed [HW:0] add_sum;
  logic               add_sat;

  always_comb begin
    add_sum = {rd_cur[HW-1], rd_cur} + {cmd_i.amount[HW-1], cmd_i.amount};
    add_sat = add_sum[HW] ^ add_sum[HW-1];
    if (!add_sat) begin
      add_val = add_sum[HW-1:0];
    end else if (add_sum[HW]) begin
      add_val = wgh_pkg::HeightMin;
    end else begin
      add_val = wgh_pkg::HeightMax;
    end
  end

  // Step pipeline valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic sat_q;
  logic clip;
  logic interior;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      wr_v_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      v1_q   <= cmd_i.step_issue;
      v2_q   <= v1_q;
      v3_q   <= v2_q && interior;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      wr_v_q <= v5_q;
      if (cmd_i.sat_clr) begin
        sat_q <= 1'b0;
      end else if (v5_q && clip) begin
        sat_q <= 1'b1;
      end
    end
  end

  // Window stage: the centre lies one row behind the newest cell
  logic [AW-1:0]        a1_q, a2_q, c3_q, c4_q, c5_q;
  logic signed [HW-1:0] win_q [wgh_pkg::WinLen];
  logic signed [HW-1:0] prv2_q, ctr3_q, prv3_q, prv4_q;
  logic [AW-1:0]        ctr_addr;
  logic signed [NsumW-1:0] nsum, nsum3_q;

  always_comb begin
    ctr_addr = a2_q - AW'(wgh_pkg::GridSize);
    interior = (ctr_addr[AW-1:CW] != '0) && (ctr_addr[AW-1:CW] != wgh_pkg::LastCoord) &&
               (ctr_addr[CW-1:0] != '0) && (ctr_addr[CW-1:0] != wgh_pkg::LastCoord);
    nsum = NsumW'(win_q[wgh_pkg::TapS]) + NsumW'(win_q[wgh_pkg::TapN]) +
           NsumW'(win_q[wgh_pkg::TapE]) + NsumW'(win_q[wgh_pkg::TapW]);
  end

  // Products, sum and rounding
  logic signed [PaW-1:0]  pa4_q;
  logic signed [PbW-1:0]  pb4_q;
  logic signed [AccW-1:0] acc5_q, rnd;
  logic signed [RndW-1:0] res;
  logic signed [HW-1:0]   res_sat;

  always_comb begin
    rnd  = acc5_q + AccW'(1 << (wgh_pkg::QShift - 1));
    res  = rnd[AccW-1:wgh_pkg::QShift];
    clip = 1'b0;
    res_sat = res[HW-1:0];
    if (!res[RndW-1] && (|res[RndW-2:HW-1])) begin
      clip = 1'b1;
      res_sat = wgh_pkg::HeightMax;
    end else if (res[RndW-1] && !(&res[RndW-2:HW-1])) begin
      clip = 1'b1;
      res_sat = wgh_pkg::HeightMin;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= cmd_i.cnt;
    a2_q <= a1_q;
    if (v1_q) begin
      win_q[0] <= rd_cur;
      for (int i = 1; i < wgh_pkg::WinLen; i++) begin
        win_q[i] <= win_q[i-1];
      end
      prv2_q <= rd_prv;
    end
    c3_q    <= ctr_addr;
    nsum3_q <= nsum;
    ctr3_q  <= win_q[wgh_pkg::TapC];
    prv3_q  <= prv2_q;
    pa4_q   <= $signed({1'b0, coupling_i}) * nsum3_q;
    pb4_q   <= $signed({1'b0, center_i}) * ctr3_q;
    prv4_q  <= prv3_q;
    c4_q    <= c3_q;
    acc5_q  <= AccW'(pa4_q) + AccW'(pb4_q) -
               (AccW'(prv4_q) <<< wgh_pkg::QShift);
    c5_q    <= c4_q;
    wr_a_q  <= c5_q;
    wr_d_q  <= res_sat;
  end

  assign stat_o.cur_height = rd_cur;
  assign stat_o.add_sat    = add_sat;
  assign stat_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q || wr_v_q);
  assign stat_o.step_sat   = sat_q;

endmodule

`default_nettype wire

/* src/wgh_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module wgh_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire wgh_pkg::in_item_t    in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output wgh_pkg::out_item_t        out_item_o,
  output wgh_pkg::dp_cmd_t          cmd_o,
  input  wire wgh_pkg::dp_stat_t    stat_i
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StAccess,
    StWrite,
    StStep,
    StDrain,
    StDone
  } state_e;

  state_e                          state_q;
  logic [wgh_pkg::AddrW-1:0]       cnt_q;
  logic                            from_cmd_q;
  logic                            out_valid_q;
  wgh_pkg::in_item_t               item_q;
  wgh_pkg::out_item_t              res_q, out_item_q;

  // Commands to the datapath decode straight from the state
  always_comb begin
    cmd_o.clr_we     = (state_q == StClear);
    cmd_o.step_issue = (state_q == StStep);
    cmd_o.add_we     = (state_q == StWrite) && (item_q.cmd == wgh_pkg::CmdAdd);
    cmd_o.rotate     = (state_q == StDrain) && stat_i.pipe_empty;
    cmd_o.zero_index = (state_q == StClear) && (cnt_q == wgh_pkg::LastAddr);
    cmd_o.sat_clr    = (state_q == StStep) && (cnt_q == '0);
    cmd_o.cnt        = cnt_q;
    cmd_o.cell_addr  = {item_q.cell_y, item_q.cell_x};
    cmd_o.amount     = item_q.amount;
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cnt_q       <= '0;
      from_cmd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // In the done state the hand-off below decides the output valid.
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          cnt_q <= cnt_q + 1'b1;
          res_q <= '0;
          if (cnt_q == wgh_pkg::LastAddr) begin
            state_q <= from_cmd_q ? StDone : StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            item_q <= in_item_i;
            cnt_q  <= '0;
            unique case (in_item_i.cmd)
              wgh_pkg::CmdClear: begin
                from_cmd_q <= 1'b1;
                state_q    <= StClear;
              end
              wgh_pkg::CmdStep: state_q <= StStep;
              default:          state_q <= StAccess;
            endcase
          end
        end
        StAccess: state_q <= StWrite;
        StWrite: begin
          res_q.height    <= (item_q.cmd == wgh_pkg::CmdRead) ? stat_i.cur_height : '0;
          res_q.saturated <= (item_q.cmd == wgh_pkg::CmdAdd) && stat_i.add_sat;
          state_q         <= StDone;
        end
        StStep: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == wgh_pkg::LastAddr) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (stat_i.pipe_empty) begin
            res_q.height    <= '0;
            res_q.saturated <= stat_i.step_sat;
            state_q         <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_item_q  <= res_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* src/wave_grid_height_update.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o   wgh_pkg::in_item_t
// out       output     out_valid_o/out_stall_i wgh_pkg::out_item_t
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Add and read go through a frame memory read, a write-back and a hand-off.
// A step streams the 16384 cells of the current frame past a two-row window,
// one per cycle, then drains a 6-stage arithmetic pipeline.
// Clear sweeps all three frame memories together, one address per cycle.
// After reset the same clearing pass runs before the first transaction.
// A finished result waits in the output register while the next transaction is taken.
module wave_grid_height_update (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire wgh_pkg::in_item_t                   in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output wgh_pkg::out_item_t                       out_item_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [wgh_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [wgh_pkg::GainW-1:0]           cfg_data_i
);

  logic [wgh_pkg::GainW-1:0] coupling_q, center_q;
  wgh_pkg::dp_cmd_t          dp_cmd;
  wgh_pkg::dp_stat_t         dp_stat;

  // Gain registers, writable at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q <= wgh_pkg::CouplingReset;
      center_q   <= wgh_pkg::CenterReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wgh_pkg::CfgCoupling: coupling_q <= cfg_data_i;
        wgh_pkg::CfgCenter:   center_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wgh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  wgh_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .coupling_i (coupling_q),
    .center_i   (center_q),
    .stat_o     (dp_stat)
  );

  // The frame ring only rotates once every step write has landed.
  a_rotate_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.rotate |-> dp_stat.pipe_empty)
    else $error("frame rotation with step writes in flight");

  // The clearing sweep never overlaps other memory traffic.
  a_clear_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clr_we |-> !dp_cmd.add_we && !dp_cmd.step_issue)
    else $error("clear sweep overlaps another access");

  // Once a transaction is taken the block is busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted back to back");

endmodule

`default_nettype wire
